/* src/hkrc_pkg.sv */
// Shared types and constants of the keyframe resync chunker.
package hkrc_pkg;

  localparam int unsigned TAIL_KEEP  = 5;
  localparam int unsigned HOLD_DEPTH = TAIL_KEEP - 1;
  localparam int unsigned BURST_MAX  = TAIL_KEEP;
  localparam int unsigned CNT_W      = $clog2(BURST_MAX + 1);

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [LEN_W-1:0]   CHUNK_LENGTH_RST  = 10'd300;
  localparam logic [LIMIT_W-1:0] SILENCE_LIMIT_RST = 16'd1000;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [4:0] NAL_SPS       = 5'd7;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_RESYNC = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_CHUNK_LENGTH  = 1'b0,
    CFG_SILENCE_LIMIT = 1'b1
  } cfg_idx_t;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_DISCARD = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       run_last;
  } out_item_t;

  // Results caused by one accepted item; entry 0 goes out first.
  typedef struct packed {
    logic                          kind;
    logic [CNT_W-1:0]              cnt;
    logic [BURST_MAX-1:0][7:0]     bytes;
    logic [BURST_MAX-1:0]          ends;
  } burst_t;

endpackage

/* src/h264_keyframe_resync_chunker_unit.sv */
// The first result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; an item with several results
//   (start code release, four or five bytes) holds the input until its last result leaves the result register.
// Items with no result need no output slot.
// Reset (rst_n, synchronous, low): waiting for a key frame, registers at 300 and 1000.
module h264_keyframe_resync_chunker_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hkrc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hkrc_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [hkrc_pkg::CFG_W-1:0] cfg_wdata
);

  hkrc_pkg::burst_t burst;
  logic             acc;
  logic             load;

  assign acc  = in_valid && in_ready;
  assign load = acc && (burst.cnt != '0);

  hkrc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (in_data),
    .burst     (burst)
  );

  hkrc_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/hkrc_scan.sv */
// Start code search, chunk position and silence tracking for each accepted item.
module hkrc_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [hkrc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       acc,
  input  hkrc_pkg::in_item_t         item,
  output hkrc_pkg::burst_t           burst
);

  logic                                          len_zero;
  logic [hkrc_pkg::LEN_W-1:0]                    len_r;
  logic [hkrc_pkg::LIMIT_W-1:0]                  limit_r;

  logic                                          wait_r, wait_nxt;
  logic [hkrc_pkg::HOLD_DEPTH-1:0][7:0]          hold_r, hold_nxt;
  logic [2:0]                                    hold_cnt_r, hold_cnt_nxt;
  logic [hkrc_pkg::LEN_W-1:0]                    pos_r, pos_nxt;
  logic [hkrc_pkg::LIMIT_W-1:0]                  ticks_r, ticks_nxt;
  logic                                          armed_r, armed_nxt;

  logic [hkrc_pkg::LEN_W:0]                      len_ext;
  logic [hkrc_pkg::LEN_W:0]                      step;
  logic [hkrc_pkg::BURST_MAX:0][hkrc_pkg::LEN_W-1:0] chain_pos;
  logic [hkrc_pkg::BURST_MAX-1:0]                chain_end;
  logic [hkrc_pkg::LIMIT_W-1:0]                  ticks_inc;
  logic [4:0]                                    hdr_type;
  logic                                          key_hdr, rel5, rel4;

  assign len_zero = (len_r == '0);
  // A length of zero stands for 1024.
  assign len_ext = len_zero ? {1'b1, {hkrc_pkg::LEN_W{1'b0}}} : {1'b0, len_r};

  // Walk the chunk position over up to five passed bytes.
  always_comb begin
    chain_pos[0] = pos_r;
    for (int i = 0; i < hkrc_pkg::BURST_MAX; i++) begin
      step = {1'b0, chain_pos[i]} + 1'b1;
      if (step >= len_ext) begin
        chain_end[i]   = 1'b1;
        chain_pos[i+1] = '0;
      end else begin
        chain_end[i]   = 1'b0;
        chain_pos[i+1] = step[hkrc_pkg::LEN_W-1:0];
      end
    end
  end

  assign hdr_type = item.data_byte[4:0] & hkrc_pkg::NAL_TYPE_MASK;
  assign key_hdr  = (hdr_type == hkrc_pkg::NAL_SPS) || (hdr_type == hkrc_pkg::NAL_IDR);
  // hold_r[3] is the newest held byte; a four-byte code wins over a three-byte one.
  assign rel5 = key_hdr && (hold_cnt_r >= 3'd4) && (hold_r[0] == 8'h00) &&
                (hold_r[1] == 8'h00) && (hold_r[2] == 8'h00) && (hold_r[3] == 8'h01);
  assign rel4 = key_hdr && !rel5 && (hold_cnt_r >= 3'd3) && (hold_r[1] == 8'h00) &&
                (hold_r[2] == 8'h00) && (hold_r[3] == 8'h01);

  assign ticks_inc = (ticks_r == {hkrc_pkg::LIMIT_W{1'b1}}) ? ticks_r : ticks_r + 1'b1;

  always_comb begin
    wait_nxt     = wait_r;
    hold_nxt     = hold_r;
    hold_cnt_nxt = hold_cnt_r;
    pos_nxt      = pos_r;
    ticks_nxt    = ticks_r;
    armed_nxt    = armed_r;
    burst        = '0;
    burst.kind   = hkrc_pkg::KIND_BYTE;
    burst.ends   = chain_end;

    case (hkrc_pkg::cmd_t'(item.cmd))
      hkrc_pkg::CMD_BYTE: begin
        armed_nxt = 1'b1;
        ticks_nxt = '0;
        if (!wait_r) begin
          burst.cnt      = 3'd1;
          burst.bytes[0] = item.data_byte;
          pos_nxt        = chain_pos[1];
        end else if (rel5) begin
          burst.cnt   = 3'd5;
          burst.bytes = {item.data_byte, hold_r[3], hold_r[2], hold_r[1], hold_r[0]};
          pos_nxt     = chain_pos[5];
          wait_nxt     = 1'b0;
          hold_nxt     = '0;
          hold_cnt_nxt = '0;
        end else if (rel4) begin
          burst.cnt   = 3'd4;
          burst.bytes = {8'h00, item.data_byte, hold_r[3], hold_r[2], hold_r[1]};
          pos_nxt     = chain_pos[4];
          wait_nxt     = 1'b0;
          hold_nxt     = '0;
          hold_cnt_nxt = '0;
        end else begin
          // Drop the oldest byte, keep the last four.
          hold_nxt     = {item.data_byte, hold_r[3], hold_r[2], hold_r[1]};
          hold_cnt_nxt = (hold_cnt_r >= 3'd4) ? 3'd4 : hold_cnt_r + 3'd1;
        end
      end
      hkrc_pkg::CMD_RESYNC: begin
        burst.cnt    = 3'd1;
        burst.kind   = hkrc_pkg::KIND_DISCARD;
        burst.ends   = '0;
        wait_nxt     = 1'b1;
        hold_nxt     = '0;
        hold_cnt_nxt = '0;
        pos_nxt      = '0;
      end
      hkrc_pkg::CMD_TICK: begin
        if (armed_r) begin
          if (ticks_inc >= limit_r) begin
            armed_nxt    = 1'b0;
            ticks_nxt    = '0;
            burst.cnt    = 3'd1;
            burst.kind   = hkrc_pkg::KIND_DISCARD;
            burst.ends   = '0;
            wait_nxt     = 1'b1;
            hold_nxt     = '0;
            hold_cnt_nxt = '0;
            pos_nxt      = '0;
          end else begin
            ticks_nxt = ticks_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= hkrc_pkg::CHUNK_LENGTH_RST;
      limit_r    <= hkrc_pkg::SILENCE_LIMIT_RST;
      wait_r     <= 1'b1;
      hold_r     <= '0;
      hold_cnt_r <= '0;
      pos_r      <= '0;
      ticks_r    <= '0;
      armed_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (hkrc_pkg::cfg_idx_t'(cfg_index))
          hkrc_pkg::CFG_CHUNK_LENGTH:  len_r   <= cfg_wdata[hkrc_pkg::LEN_W-1:0];
          hkrc_pkg::CFG_SILENCE_LIMIT: limit_r <= cfg_wdata[hkrc_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        wait_r     <= wait_nxt;
        hold_r     <= hold_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        pos_r      <= pos_nxt;
        ticks_r    <= ticks_nxt;
        armed_r    <= armed_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pass_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wait_r |-> (hold_cnt_r == 3'd0))
    else $error("hold window not empty while passing");
  a_hold_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r <= 3'd4)
    else $error("hold count beyond depth");
  a_discard_single: assert property (@(posedge clk) disable iff (!rst_n)
    (burst.kind == hkrc_pkg::KIND_DISCARD) |-> (burst.cnt == 3'd1))
    else $error("discard burst with more than one result");
`endif

endmodule

/* src/hkrc_burst.sv */
// Result register that sends out the results of one item, one per cycle while out_ready is high.
module hkrc_burst (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  hkrc_pkg::burst_t    burst,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output hkrc_pkg::out_item_t out_data
);

  logic [hkrc_pkg::CNT_W-1:0]             cnt_r;
  logic                                   kind_r;
  logic [hkrc_pkg::BURST_MAX-1:0][7:0]    bytes_r;
  logic [hkrc_pkg::BURST_MAX-1:0]         ends_r;
  logic                                   take;
  logic                                   last;

  assign last      = (cnt_r == 3'd1);
  assign take      = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  // Accept a new item when empty or while the final result of the current one leaves.
  assign can_take  = !out_valid || (out_ready && last);

  assign out_data.kind      = kind_r;
  assign out_data.out_byte  = bytes_r[0];
  assign out_data.chunk_end = ends_r[0];
  assign out_data.run_last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= burst.kind;
      bytes_r <= burst.bytes;
      ends_r  <= burst.ends;
    end else if (take) begin
      // Advance to the next result.
      bytes_r <= {8'h00, bytes_r[hkrc_pkg::BURST_MAX-1:1]};
      ends_r  <= {1'b0, ends_r[hkrc_pkg::BURST_MAX-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd5)
    else $error("result count beyond burst size");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 3'd0 || (take && last)))
    else $error("burst loaded over pending results");
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last && !load) |=> (cnt_r == 3'd0))
    else $error("results remain after last one taken");
`endif

endmodule

/* dv/hkrc_chunk_checker.sv */
// Checker: predicts the chunker's results from the observed items and compares them in order.
`timescale 1ns / 100ps
module hkrc_chunk_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  hkrc_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  hkrc_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [hkrc_pkg::CFG_W-1:0] cfg_wdata,
  output int unsigned                mismatches,
  output int unsigned                pending
);

  // Predictor copy of the configuration and state
  logic [hkrc_pkg::LEN_W-1:0]   chunk_len;
  logic [hkrc_pkg::LIMIT_W-1:0] quiet_limit;
  logic                         key_wait;
  logic [7:0]                   held [hkrc_pkg::HOLD_DEPTH];
  int unsigned                  held_cnt;
  logic [hkrc_pkg::LEN_W-1:0]   chunk_pos;
  logic [hkrc_pkg::LIMIT_W-1:0] quiet_ticks;
  logic                         quiet_armed;

  hkrc_pkg::out_item_t chunk_results_q[$];  // expected results, oldest first
  hkrc_pkg::out_item_t item_results_q[$];   // results of the item being predicted
  int unsigned         miss_cnt = 0;

  task automatic clear_hold();
    for (int i = 0; i < hkrc_pkg::HOLD_DEPTH; i++) held[i] = 8'h00;
    held_cnt = 0;
  endtask

  task automatic emit_result(logic kind, logic [7:0] b, logic ends);
    hkrc_pkg::out_item_t r;
    r.kind      = kind;
    r.out_byte  = b;
    r.chunk_end = ends;
    r.run_last  = 1'b0;
    item_results_q.push_back(r);
  endtask

  // Count a passed byte into the current chunk; length zero means 1024.
  task automatic pass_through(logic [7:0] b);
    int unsigned len;
    int unsigned next;
    logic        ends;
    len  = (chunk_len == '0) ? 1024 : chunk_len;
    next = chunk_pos + 1;
    ends = 1'b0;
    if (next >= len) begin
      ends = 1'b1;
      next = 0;
    end
    chunk_pos = hkrc_pkg::LEN_W'(next);
    emit_result(hkrc_pkg::KIND_BYTE, b, ends);
  endtask

  task automatic force_resync();
    emit_result(hkrc_pkg::KIND_DISCARD, 8'h00, 1'b0);
    key_wait  = 1'b1;
    clear_hold();
    chunk_pos = '0;
  endtask

  task automatic predict_chunker_results(hkrc_pkg::in_item_t it);
    logic [7:0]          win [hkrc_pkg::TAIL_KEEP];
    int unsigned         n;
    int unsigned         start;
    int unsigned         rel;
    logic                is_key;
    hkrc_pkg::out_item_t last;
    item_results_q.delete();
    case (it.cmd)
      hkrc_pkg::CMD_BYTE: begin
        quiet_armed = 1'b1;
        quiet_ticks = '0;
        if (!key_wait) begin
          pass_through(it.data_byte);
        end else begin
          n = (held_cnt > hkrc_pkg::HOLD_DEPTH) ? hkrc_pkg::HOLD_DEPTH : held_cnt;
          for (int i = 0; i < n; i++) win[i] = held[i];
          win[n] = it.data_byte;
          n++;
          rel    = 0;
          start  = 0;
          is_key = ((it.data_byte[4:0] & hkrc_pkg::NAL_TYPE_MASK) == hkrc_pkg::NAL_SPS) ||
                   ((it.data_byte[4:0] & hkrc_pkg::NAL_TYPE_MASK) == hkrc_pkg::NAL_IDR);
          // Prefer the 4-byte start code when the whole window holds it
          if (is_key && n >= 5 && win[n-5] == 8'h00 && win[n-4] == 8'h00 &&
              win[n-3] == 8'h00 && win[n-2] == 8'h01) begin
            start = n - 5;
            rel   = 5;
          end else if (is_key && n >= 4 && win[n-4] == 8'h00 && win[n-3] == 8'h00 &&
                       win[n-2] == 8'h01) begin
            start = n - 4;
            rel   = 4;
          end
          if (rel != 0) begin
            key_wait = 1'b0;
            clear_hold();
            for (int i = 0; i < rel; i++) pass_through(win[start+i]);
          end else if (n > hkrc_pkg::HOLD_DEPTH) begin
            for (int i = 0; i < hkrc_pkg::HOLD_DEPTH; i++) held[i] = win[i+1];
            held_cnt = hkrc_pkg::HOLD_DEPTH;
          end else begin
            for (int i = 0; i < n; i++) held[i] = win[i];
            held_cnt = n;
          end
        end
      end
      hkrc_pkg::CMD_RESYNC: force_resync();
      hkrc_pkg::CMD_TICK: begin
        if (quiet_armed) begin
          if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 1'b1;
          if (quiet_ticks >= quiet_limit) begin
            quiet_armed = 1'b0;
            quiet_ticks = '0;
            force_resync();
          end
        end
      end
      default: ;
    endcase
    if (item_results_q.size() != 0) begin
      last = item_results_q.pop_back();
      last.run_last = 1'b1;
      item_results_q.push_back(last);
      foreach (item_results_q[i]) chunk_results_q.push_back(item_results_q[i]);
    end
  endtask

  task automatic flag_mismatch(bit have_want, hkrc_pkg::out_item_t want);
    miss_cnt++;
    if (miss_cnt <= 10) begin
      if (have_want)
        $display("%0t: result differs: expected kind %0d byte %02h end %0d last %0d,",
                 $time, want.kind, want.out_byte, want.chunk_end, want.run_last,
                 " got kind %0d byte %02h end %0d last %0d",
                 out_data.kind, out_data.out_byte, out_data.chunk_end, out_data.run_last);
      else
        $display("%0t: unexpected result: kind %0d byte %02h end %0d last %0d",
                 $time, out_data.kind, out_data.out_byte, out_data.chunk_end,
                 out_data.run_last);
    end
  endtask

  always @(posedge clk) begin
    hkrc_pkg::out_item_t want;
    if (!rst_n) begin
      chunk_len   = hkrc_pkg::CHUNK_LENGTH_RST;
      quiet_limit = hkrc_pkg::SILENCE_LIMIT_RST;
      key_wait    = 1'b1;
      clear_hold();
      chunk_pos   = '0;
      quiet_ticks = '0;
      quiet_armed = 1'b0;
      chunk_results_q.delete();
    end else begin
      // Check the result first: an item accepted now cannot have a result yet
      if (out_valid && out_ready) begin
        if (chunk_results_q.size() == 0) begin
          want = '0;
          flag_mismatch(1'b0, want);
        end else begin
          want = chunk_results_q.pop_front();
          if (want.kind !== out_data.kind || want.out_byte !== out_data.out_byte ||
              want.chunk_end !== out_data.chunk_end || want.run_last !== out_data.run_last)
            flag_mismatch(1'b1, want);
        end
      end
      if (cfg_we) begin
        if (cfg_index == hkrc_pkg::CFG_CHUNK_LENGTH) chunk_len = cfg_wdata[hkrc_pkg::LEN_W-1:0];
        else quiet_limit = cfg_wdata[hkrc_pkg::LIMIT_W-1:0];
      end
      if (in_valid && in_ready) predict_chunker_results(in_data);
    end
    pending    <= chunk_results_q.size();
    mismatches <= miss_cnt;
  end

endmodule

/* dv/h264_keyframe_resync_chunker_unit_tb.sv */
// Testbench top: drives items and register writes into the chunker and reports the verdict.
`timescale 1ns / 100ps
module h264_keyframe_resync_chunker_unit_tb;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 36;

  localparam logic [hkrc_pkg::LEN_W-1:0] PHASE_LEN [PHASES] =
    '{10'd1, 10'd1023, 10'd7, 10'd0, 10'd3, 10'd64};
  localparam logic [hkrc_pkg::LIMIT_W-1:0] PHASE_LIMIT [PHASES] =
    '{16'd1, 16'd65535, 16'd4, 16'd0, 16'd3, 16'd12};

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  hkrc_pkg::in_item_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  hkrc_pkg::out_item_t        out_data;
  logic                       cfg_we    = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [hkrc_pkg::CFG_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent;
  bit          no_idle = 1'b0;

  h264_keyframe_resync_chunker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hkrc_chunk_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("h264_keyframe_resync_chunker_unit: mismatch");
    $finish;
  end

  function automatic int unsigned idle_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // Present one item and hold it until accepted; keep valid high across back-to-back items.
  task automatic send_item(hkrc_pkg::cmd_t c, logic [7:0] b);
    int unsigned        gap;
    hkrc_pkg::in_item_t it;
    gap          = idle_gap();
    it.cmd       = c;
    it.data_byte = b;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c != hkrc_pkg::CMD_NONE) sent++;
  endtask

  task automatic write_reg(hkrc_pkg::cfg_idx_t idx, logic [hkrc_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: wait for every expected result, then idle so that items without one also finish.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: drop ready for a random gap before each result, unless idle gaps are off.
  initial begin : drain_results
    int unsigned gap;
    @(posedge clk);
    forever begin
      gap = idle_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    logic [7:0]  hdr;
    logic [7:0]  b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: ignored command, unarmed tick, resync with nothing partial
    send_item(hkrc_pkg::CMD_NONE, 8'hFF);
    send_item(hkrc_pkg::CMD_TICK, 8'h00);
    send_item(hkrc_pkg::CMD_RESYNC, 8'h00);
    // Older held byte dropped, then a 4-byte start code with an IDR header
    send_item(hkrc_pkg::CMD_BYTE, 8'hFF);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h01);
    send_item(hkrc_pkg::CMD_BYTE, 8'h65);
    send_item(hkrc_pkg::CMD_BYTE, 8'hAB);
    send_item(hkrc_pkg::CMD_TICK, 8'hFF);
    send_item(hkrc_pkg::CMD_RESYNC, 8'hFF);
    // Non-key header stays waiting; 3-byte code with an SPS header releases
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h01);
    send_item(hkrc_pkg::CMD_BYTE, 8'h41);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h01);
    send_item(hkrc_pkg::CMD_BYTE, 8'hE7);

    // Chunk length zero and silence limit zero
    settle();
    write_reg(hkrc_pkg::CFG_CHUNK_LENGTH, 16'h0000);
    write_reg(hkrc_pkg::CFG_SILENCE_LIMIT, 16'h0000);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h00);
    send_item(hkrc_pkg::CMD_BYTE, 8'h01);
    send_item(hkrc_pkg::CMD_BYTE, 8'h25);
    send_item(hkrc_pkg::CMD_BYTE, 8'h11);
    // Lower the chunk length below the current position; upper write bits are dropped
    settle();
    write_reg(hkrc_pkg::CFG_CHUNK_LENGTH, 16'hFC02);
    send_item(hkrc_pkg::CMD_BYTE, 8'h33);
    send_item(hkrc_pkg::CMD_BYTE, 8'h44);
    send_item(hkrc_pkg::CMD_TICK, 8'h00);
    send_item(hkrc_pkg::CMD_TICK, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(hkrc_pkg::CFG_CHUNK_LENGTH, hkrc_pkg::CFG_W'(PHASE_LEN[p]));
      write_reg(hkrc_pkg::CFG_SILENCE_LIMIT, PHASE_LIMIT[p]);
      no_idle = (p % 3 == 1);
      sent    = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Junk, a start code with a key header, then payload
          repeat ($urandom_range(0, 3)) send_item(hkrc_pkg::CMD_BYTE, 8'($urandom));
          if ($urandom_range(0, 1)) send_item(hkrc_pkg::CMD_BYTE, 8'h00);
          send_item(hkrc_pkg::CMD_BYTE, 8'h00);
          send_item(hkrc_pkg::CMD_BYTE, 8'h00);
          send_item(hkrc_pkg::CMD_BYTE, 8'h01);
          hdr      = 8'($urandom);
          hdr[4:0] = $urandom_range(0, 1) ? hkrc_pkg::NAL_SPS : hkrc_pkg::NAL_IDR;
          send_item(hkrc_pkg::CMD_BYTE, hdr);
          repeat ($urandom_range(1, 12)) send_item(hkrc_pkg::CMD_BYTE, 8'($urandom));
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 8)) send_item(hkrc_pkg::CMD_TICK, 8'($urandom));
        end else if (pick < 78) begin
          send_item(hkrc_pkg::CMD_RESYNC, 8'($urandom));
        end else if (pick < 90) begin
          // Broken sequences: bytes mostly zero or one, headers of any type
          repeat ($urandom_range(2, 6)) begin
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            send_item(hkrc_pkg::CMD_BYTE, b);
          end
        end else begin
          send_item(hkrc_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("h264_keyframe_resync_chunker_unit: match");
    else
      $display("h264_keyframe_resync_chunker_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
src/hkrc_pkg.sv
src/hkrc_scan.sv
src/hkrc_burst.sv
src/h264_keyframe_resync_chunker_unit.sv
dv/hkrc_chunk_checker.sv
dv/h264_keyframe_resync_chunker_unit_tb.sv
